[src/wsfe_pkg.sv]
package wsfe_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int HDR_IDX_W   = 4;

    localparam logic       ACT_START   = 1'b0;
    localparam logic       ACT_PAYLOAD = 1'b1;

    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [6:0] LEN16_CODE  = 7'd126;
    localparam logic [6:0] LEN64_CODE  = 7'd127;
    localparam logic [31:0] LEN16_LIMIT = 32'd65536;

    typedef enum logic [1:0] {
        LEN_FORM7,
        LEN_FORM16,
        LEN_FORM64
    } len_form_t;

    // One queue entry: either a whole frame header or one finished payload byte
    typedef struct packed {
        logic        is_header;
        len_form_t   form;
        logic        len_zero;
        logic [3:0]  opcode;
        logic [31:0] len;
        logic [31:0] key;
        logic [7:0]  data;
        logic        last;
    } wsfe_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } wsfe_qstat_t;

    function automatic logic [7:0] sel_byte(input logic [31:0] w, input logic [1:0] i);
        return w[{i, 3'b000} +: 8];
    endfunction

    function automatic logic [HDR_IDX_W-1:0] key_start(input len_form_t form);
        logic [HDR_IDX_W-1:0] ks;
        case (form)
            LEN_FORM7:  ks = HDR_IDX_W'(2);
            LEN_FORM16: ks = HDR_IDX_W'(4);
            LEN_FORM64: ks = HDR_IDX_W'(10);
            default:    ks = HDR_IDX_W'(2);
        endcase
        return ks;
    endfunction

    function automatic logic [HDR_IDX_W-1:0] header_last(input len_form_t form);
        return key_start(form) + HDR_IDX_W'(3);
    endfunction

    function automatic logic [7:0] header_byte(input wsfe_cmd_t c,
                                               input logic [HDR_IDX_W-1:0] idx);
        logic [HDR_IDX_W-1:0] ks;
        logic [HDR_IDX_W-1:0] kp;
        logic [HDR_IDX_W-1:0] lp;
        logic [7:0]           b;
        ks = key_start(c.form);
        kp = idx - ks;
        lp = HDR_IDX_W'(9) - idx;
        if (idx == HDR_IDX_W'(0)) begin
            b = FIN_BIT | {4'b0000, c.opcode};
        end
        else if (idx == HDR_IDX_W'(1)) begin
            case (c.form)
                LEN_FORM7:  b = MASK_BIT | {1'b0, c.len[6:0]};
                LEN_FORM16: b = MASK_BIT | {1'b0, LEN16_CODE};
                LEN_FORM64: b = MASK_BIT | {1'b0, LEN64_CODE};
                default:    b = MASK_BIT;
            endcase
        end
        else if (idx < ks) begin
            if (c.form == LEN_FORM16) begin
                b = (idx == HDR_IDX_W'(2)) ? c.len[15:8] : c.len[7:0];
            end
            else if (idx < HDR_IDX_W'(6)) begin
                b = 8'h00;
            end
            else begin
                b = sel_byte(c.len, lp[1:0]);
            end
        end
        else begin
            b = sel_byte(c.key, 2'd3 - kp[1:0]);
        end
        return b;
    endfunction

endpackage

[src/wsfe_if.sv]
interface wsfe_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  frame_opcode;
    logic [31:0] frame_length;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;

    modport source (output valid, action, frame_opcode, frame_length, mask_key,
                    payload_byte, input ready);
    modport sink   (input valid, action, frame_opcode, frame_length, mask_key,
                    payload_byte, output ready);
endinterface

interface wsfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

[src/wsfe_front.sv]
module wsfe_front
    import wsfe_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    wsfe_cmd_if.sink        cmd,
    input  wsfe_qstat_t     qstat,
    output logic            push,
    output wsfe_cmd_t       push_cmd
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [31:0] bytes_remaining_reg;
    logic [31:0] bytes_remaining_next;
    logic [31:0] held_mask_reg;
    logic [31:0] held_mask_next;
    logic [1:0]  mask_phase_reg;
    logic [1:0]  mask_phase_next;
    logic        accept;
    logic [31:0] rem_dec;
    logic        is_last;

    assign cmd.ready = !qstat.full;
    assign accept    = cmd.valid && cmd.ready;
    assign rem_dec   = bytes_remaining_reg - 32'd1;
    assign is_last   = (rem_dec == 32'd0);

    always_comb
    begin
        frame_open_next      = frame_open_reg;
        bytes_remaining_next = bytes_remaining_reg;
        held_mask_next       = held_mask_reg;
        mask_phase_next      = mask_phase_reg;
        push                 = 1'b0;

        push_cmd.is_header = (cmd.action == ACT_START);
        push_cmd.len_zero  = (cmd.frame_length == 32'd0);
        push_cmd.opcode    = cmd.frame_opcode;
        push_cmd.len       = cmd.frame_length;
        push_cmd.key       = cmd.mask_key;
        push_cmd.data      = cmd.payload_byte ^ sel_byte(held_mask_reg, 2'd3 - mask_phase_reg);
        push_cmd.last      = is_last;
        if (cmd.frame_length < {25'd0, LEN16_CODE}) begin
            push_cmd.form = LEN_FORM7;
        end
        else if (cmd.frame_length < LEN16_LIMIT) begin
            push_cmd.form = LEN_FORM16;
        end
        else begin
            push_cmd.form = LEN_FORM64;
        end

        if (accept) begin
            if (cmd.action == ACT_START) begin
                // abandon any open frame and load the new one
                push                 = 1'b1;
                held_mask_next       = cmd.mask_key;
                mask_phase_next      = 2'd0;
                bytes_remaining_next = cmd.frame_length;
                frame_open_next      = (cmd.frame_length != 32'd0);
            end
            else if (frame_open_reg) begin
                push                 = 1'b1;
                bytes_remaining_next = rem_dec;
                mask_phase_next      = mask_phase_reg + 2'd1;
                if (is_last) begin
                    frame_open_next = 1'b0;
                end
            end
            // payload outside a frame: drop
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_open_reg      <= 1'b0;
            bytes_remaining_reg <= 32'd0;
            held_mask_reg       <= 32'd0;
            mask_phase_reg      <= 2'd0;
        end
        else begin
            frame_open_reg      <= frame_open_next;
            bytes_remaining_reg <= bytes_remaining_next;
            held_mask_reg       <= held_mask_next;
            mask_phase_reg      <= mask_phase_next;
        end
    end

endmodule

[src/wsfe_queue.sv]
module wsfe_queue
    import wsfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  wsfe_cmd_t    push_cmd,
    input  logic         pop,
    output wsfe_cmd_t    head,
    output wsfe_qstat_t  qstat
);

    wsfe_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign qstat.empty = (count_reg == QCNT_W'(0));
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[src/wsfe_back.sv]
module wsfe_back
    import wsfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  wsfe_cmd_t    head,
    input  wsfe_qstat_t  qstat,
    output logic         pop,
    wsfe_byte_if.source  stream
);

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 frame_end_reg;
    logic [HDR_IDX_W-1:0] idx_reg;
    logic [HDR_IDX_W-1:0] idx_next;
    logic                 load;
    logic                 hdr_done;
    logic [7:0]           byte_next;
    logic                 end_next;

    assign stream.valid     = out_valid_reg;
    assign stream.out_byte  = out_byte_reg;
    assign stream.frame_end = frame_end_reg;

    assign load     = !out_valid_reg || stream.ready;
    assign hdr_done = (idx_reg == header_last(head.form));

    always_comb
    begin
        pop       = 1'b0;
        idx_next  = idx_reg;
        byte_next = head.data;
        end_next  = head.last;
        if (head.is_header) begin
            byte_next = header_byte(head, idx_reg);
            end_next  = hdr_done && head.len_zero;
        end
        if (load && !qstat.empty) begin
            if (head.is_header) begin
                // walk the header one byte a beat, release the entry on its last byte
                if (hdr_done) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else begin
                    idx_next = idx_reg + HDR_IDX_W'(1);
                end
            end
            else begin
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else begin
            idx_reg <= idx_next;
            if (load) begin
                out_valid_reg <= !qstat.empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !qstat.empty) begin
            out_byte_reg  <= byte_next;
            frame_end_reg <= end_next;
        end
    end

endmodule

[src/websocket_frame_encoder.sv]
// Masked client WebSocket frame encoder.
// cmd: valid/ready channel of items. A start item (action 0) carries opcode,
//   payload length and mask key; a payload item (action 1) carries one byte.
// stream: valid/ready channel of encoded frame bytes, frame_end on the last.
// A start item produces 6, 8 or 14 header bytes (7-bit, 16-bit or 64-bit
// length form); each payload byte inside a frame produces one masked byte.
// Payload bytes outside a frame are dropped; a start abandons an open frame.
// An accepted item lands in a 4-entry queue at the accepting edge, and its
// bytes are registered into the output stage from the head of the queue.
// Payload bytes pass one per cycle while stream is ready; a header occupies
// the output stage for each of its bytes in turn, which is what bounds the
// rate while headers stream. The queue lets items keep arriving during a
// header. When stream stalls, the output register holds its byte and the
// queue fills; cmd.ready drops once the queue holds 4 entries.
// Reset clears the frame state, empties the queue and the output stage.
module websocket_frame_encoder
    import wsfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wsfe_cmd_if.sink    cmd,
    wsfe_byte_if.source stream
);

    wsfe_qstat_t qstat;
    wsfe_cmd_t   push_cmd;
    wsfe_cmd_t   head;
    logic        push;
    logic        pop;

    wsfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .qstat    (qstat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    wsfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    wsfe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .stream (stream)
    );

endmodule

[dv/websocket_frame_encoder_tb.sv]
`timescale 1ns / 1ps

module websocket_frame_encoder_tb;
    import wsfe_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic        action;
        logic [3:0]  opcode;
        logic [31:0] len;
        logic [31:0] key;
        logic [7:0]  data;
    } ws_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic clk;
    logic rst_n;

    wsfe_cmd_if  cmd_ch();
    wsfe_byte_if byte_ch();

    websocket_frame_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .stream (byte_ch)
    );

    // Encoder state mirrored for prediction
    logic        frame_open = 1'b0;
    logic [31:0] bytes_left = '0;
    logic [31:0] held_key = '0;
    logic [1:0]  key_phase = '0;

    frame_byte_t pending_bytes[$];

    bit sender_idles = 1'b1;
    bit sink_idles = 1'b1;

    int errors = 0;
    int items_done = 0;
    int bytes_checked = 0;
    int frames_started = 0;
    int bytes_masked = 0;
    int bytes_dropped = 0;
    int form7_frames = 0;
    int form16_frames = 0;
    int form64_frames = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void queue_frame_byte(input logic [7:0] b, input logic last);
        frame_byte_t fb;
        fb.data = b;
        fb.last = last;
        pending_bytes.insert(pending_bytes.size(), fb);
    endfunction

    task automatic predict_encoding(input ws_item_t it);
        logic [7:0] mask_byte;
        if (it.action == ACT_START)
        begin
            queue_frame_byte(FIN_BIT | {4'b0000, it.opcode}, 1'b0);
            if (it.len < 32'(LEN16_CODE))
            begin
                queue_frame_byte(MASK_BIT | {1'b0, it.len[6:0]}, 1'b0);
                form7_frames++;
            end
            else if (it.len < LEN16_LIMIT)
            begin
                queue_frame_byte(MASK_BIT | {1'b0, LEN16_CODE}, 1'b0);
                queue_frame_byte(it.len[15:8], 1'b0);
                queue_frame_byte(it.len[7:0], 1'b0);
                form16_frames++;
            end
            else
            begin
                queue_frame_byte(MASK_BIT | {1'b0, LEN64_CODE}, 1'b0);
                repeat (4) queue_frame_byte(8'h00, 1'b0);
                for (int i = 3; i >= 0; i--)
                    queue_frame_byte(it.len[8*i +: 8], 1'b0);
                form64_frames++;
            end
            // an empty frame ends on its last key byte
            for (int i = 3; i >= 0; i--)
                queue_frame_byte(it.key[8*i +: 8], (i == 0) && (it.len == '0));
            held_key = it.key;
            key_phase = '0;
            bytes_left = it.len;
            frame_open = (it.len != '0);
            frames_started++;
            items_done++;
        end
        else if (!frame_open)
        begin
            bytes_dropped++;
        end
        else
        begin
            mask_byte = held_key[8*(3 - int'(key_phase)) +: 8];
            bytes_left = bytes_left - 1;
            queue_frame_byte(it.data ^ mask_byte, bytes_left == '0);
            key_phase = key_phase + 2'd1;
            if (bytes_left == '0)
                frame_open = 1'b0;
            bytes_masked++;
            items_done++;
        end
    endtask

    function automatic ws_item_t start_item(input logic [3:0] op, input logic [31:0] len,
                                            input logic [31:0] key);
        ws_item_t it;
        it.action = ACT_START;
        it.opcode = op;
        it.len = len;
        it.key = key;
        it.data = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic ws_item_t payload_item(input logic [7:0] b);
        ws_item_t it;
        it.action = ACT_PAYLOAD;
        it.opcode = 4'($urandom_range(15));
        it.len = $urandom();
        it.key = $urandom();
        it.data = b;
        return it;
    endfunction

    task automatic send_item(input ws_item_t it);
        @(negedge clk);
        while (sender_idles && $urandom_range(99) < 12)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.action = it.action;
        cmd_ch.frame_opcode = it.opcode;
        cmd_ch.frame_length = it.len;
        cmd_ch.mask_key = it.key;
        cmd_ch.payload_byte = it.data;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predict_encoding(it);
    endtask

    task automatic send_payload_run(input int count);
        for (int i = 0; i < count; i++)
            send_item(payload_item(8'($urandom_range(255))));
    endtask

    // Hold off the sender until every predicted byte has left the block
    task automatic wait_for_stream_drain();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_frame();
        send_item(start_item(4'h0, 32'd0, 32'hFFFF_FFFF));
        send_item(payload_item(8'hFF));
        wait_for_stream_drain();
    endtask

    task automatic test_length_forms();
        send_item(start_item(4'hF, 32'd125, 32'h0000_0000));
        send_item(payload_item(8'h00));
        send_item(start_item(4'h1, 32'd126, 32'hFFFF_FFFF));
        send_item(payload_item(8'hFF));
        send_item(start_item(4'h2, 32'd65535, 32'hA5C3_0F96));
        send_item(payload_item(8'h3C));
        send_item(start_item(4'h8, 32'd65536, 32'h5A3C_F069));
        send_item(payload_item(8'hC3));
        send_item(start_item(4'h9, 32'hFFFF_FFFF, 32'h1234_5678));
        send_item(payload_item(8'h81));
        wait_for_stream_drain();
    endtask

    task automatic test_short_frame();
        send_item(start_item(4'hA, 32'd5, 32'h8040_2010));
        send_item(payload_item(8'h00));
        send_item(payload_item(8'hFF));
        send_item(payload_item(8'h5A));
        send_item(payload_item(8'hA5));
        send_item(payload_item(8'h3C));
        send_item(payload_item(8'h77));
        wait_for_stream_drain();
    endtask

    task automatic test_abandoned_frame();
        send_item(start_item(4'h1, 32'd3, 32'hDEAD_BEEF));
        send_item(payload_item(8'h11));
        send_item(start_item(4'h2, 32'd1, 32'h0F0F_F0F0));
        send_item(payload_item(8'h22));
        wait_for_stream_drain();
    endtask

    task automatic test_random_frames();
        int base;
        int progress;
        int kind;
        logic [31:0] len;
        base = items_done;
        while (items_done - base < RANDOM_ITEMS)
        begin
            progress = items_done - base;
            // quiet stretch: both sides run flat out
            sender_idles = !(progress > 150 && progress < 300);
            sink_idles = sender_idles;
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                len = $urandom_range(12);
                send_item(start_item(4'($urandom_range(15)), len, $urandom()));
                send_payload_run(len);
                if ($urandom_range(4) == 0)
                    send_payload_run(1);
            end
            else if (kind < 70)
            begin
                len = $urandom_range(40, 13);
                send_item(start_item(4'($urandom_range(15)), len, $urandom()));
                send_payload_run(len);
            end
            else if (kind < 73)
            begin
                len = $urandom_range(130, 126);
                send_item(start_item(4'($urandom_range(15)), len, $urandom()));
                send_payload_run(len);
            end
            else if (kind < 79)
            begin
                len = $urandom_range(65535, 126);
                send_item(start_item(4'($urandom_range(15)), len, $urandom()));
                send_payload_run($urandom_range(6));
            end
            else if (kind < 85)
            begin
                len = $urandom();
                send_item(start_item(4'($urandom_range(15)), len, $urandom()));
                send_payload_run($urandom_range(6));
            end
            else if (kind < 95)
            begin
                len = $urandom_range(12, 2);
                send_item(start_item(4'($urandom_range(15)), len, $urandom()));
                send_payload_run($urandom_range(len - 1));
            end
            else
            begin
                send_payload_run($urandom_range(3, 1));
            end
            if ($urandom_range(19) == 0)
                wait_for_stream_drain();
        end
        sender_idles = 1'b1;
        sink_idles = 1'b1;
    endtask

    initial
    begin
        byte_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            byte_ch.ready = !(sink_idles && $urandom_range(99) < 12);
        end
    end

    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected beat, got byte %02h frame_end %0b",
                         $time, byte_ch.out_byte, byte_ch.frame_end);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_ch.out_byte !== want.data)
                begin
                    $display("%0t: out_byte mismatch, expected %02h got %02h",
                             $time, want.data, byte_ch.out_byte);
                    errors++;
                end
                if (byte_ch.frame_end !== want.last)
                begin
                    $display("%0t: frame_end mismatch, expected %0b got %0b",
                             $time, want.last, byte_ch.frame_end);
                    errors++;
                end
                bytes_checked++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_START;
        cmd_ch.frame_opcode = '0;
        cmd_ch.frame_length = '0;
        cmd_ch.mask_key = '0;
        cmd_ch.payload_byte = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_frame();
        test_length_forms();
        test_short_frame();
        test_abandoned_frame();
        test_random_frames();

        wait_for_stream_drain();
        // catch any stray beat from dropped items still in flight
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d frame headers (%0d short, %0d 16-bit, %0d 64-bit length form),",
                 frames_started, form7_frames, form16_frames, form64_frames);
        $display("%0d masked payload bytes, %0d dropped strays; %0d beats checked, %0d errors",
                 bytes_masked, bytes_dropped, bytes_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d beats still pending", pending_bytes.size());
        $display("Verification failed");
        $finish;
    end

endmodule

[websocket_frame_encoder.f]
src/wsfe_pkg.sv
src/wsfe_if.sv
src/wsfe_front.sv
src/wsfe_queue.sv
src/wsfe_back.sv
src/websocket_frame_encoder.sv
dv/websocket_frame_encoder_tb.sv
